>>> rtl/core/pnm_pkg.sv
// Package for the PNM body pixel decoder: format and register codes, FSM states, divider request, constants.
// No dependencies.
package pnm_pkg;

    localparam int MaxDimension = 32767;

    typedef enum logic [2:0] {
        FMT_P6 = 3'd0,
        FMT_P5 = 3'd1,
        FMT_P4 = 3'd2,
        FMT_P3 = 3'd3,
        FMT_P2 = 3'd4,
        FMT_P1 = 3'd5
    } pnm_format_t;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_MAXVAL = 2'd3
    } pnm_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BITS,
        ST_OUT
    } pnm_state_t;

    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [15:0] divisor;
    } pnm_div_req_t;

endpackage

>>> rtl/core/pnm_divider.sv
// Shared restoring divider, one quotient bit per cycle, for ASCII scaling.
// Depends on pnm_pkg.
module pnm_divider
    import pnm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  pnm_div_req_t req,
    output logic         done,
    output logic [23:0]  quotient
);

    logic [23:0] quot_reg, quot_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        trial     = '0;
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, quot_reg[23]};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next  = 16'(trial - {1'b0, dsr_reg});
                quot_next = {quot_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[15:0];
                quot_next = {quot_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
            end
        end
        else
        begin
            done = (cnt_reg == 5'd24);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= (done) ? 5'd0 : cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign quotient = quot_reg;

endmodule

>>> rtl/core/pnm_body_pixel_decoder.sv
// Top level of the PNM body pixel decoder: sequencer, pixel assembly, output register.
// Depends on pnm_pkg and pnm_divider.
//
// One body byte is taken per transfer on s_axis and decoded pixels leave on m_axis, one per
// transfer, with tlast on the final pixel. A binary P6 or P5 byte is taken in ST_IDLE and
// decoded in ST_OUT. A bitmap byte is unpacked one bit per cycle, while the output can take
// a pixel, up to the row end or its last bit. A digit is taken in ST_IDLE and accumulated in
// ST_OUT; a terminator of an ASCII number whose max value is not 255 goes through the shared
// bit-serial divider in ST_DIV. The input is not ready while a byte is being worked on or
// while a pixel waits in the output register.
module pnm_body_pixel_decoder
    import pnm_pkg::*;
#(
    parameter int MAX_DIMENSION = MaxDimension
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic        m_axis_tlast,   // last_pixel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [2:0]  fmt_reg;
    logic [14:0] width_reg, height_reg;
    logic [15:0] maxv_reg;

    pnm_state_t  state_reg, state_next;
    logic [29:0] emitted_reg, emitted_next;
    logic [1:0]  slot_reg, slot_next;
    logic [7:0]  hred_reg, hred_next, hgrn_reg, hgrn_next;
    logic [14:0] col_reg, col_next;
    logic [15:0] acc_reg, acc_next;
    logic        innum_reg, innum_next, done_reg, done_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  bit_reg, bit_next;
    logic        ov_reg, ov_next, olast_reg, olast_next;
    logic [23:0] odata_reg, odata_next;

    logic [29:0] total;
    logic [15:0] emax;
    logic [2:0]  rot;
    logic [7:0]  bsamp;
    logic [19:0] acc10;
    logic [23:0] scaled;
    logic [7:0]  asamp;
    logic        div_done;
    logic [23:0] quotient;
    pnm_div_req_t div_req;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

    always_comb
    begin
        if (width_reg == 15'd0 || height_reg == 15'd0 ||
            {17'd0, width_reg} > MAX_DIMENSION || {17'd0, height_reg} > MAX_DIMENSION)
        begin
            total = '0;
        end
        else
        begin
            total = 30'(width_reg * height_reg);
        end
        emax = (maxv_reg == 16'd0) ? 16'd1 : maxv_reg;
        if (emax <= 16'd1)       rot = 3'd7;
        else if (emax <= 16'd3)  rot = 3'd6;
        else if (emax <= 16'd7)  rot = 3'd5;
        else if (emax <= 16'd15) rot = 3'd4;
        else if (emax <= 16'd31) rot = 3'd3;
        else if (emax <= 16'd63) rot = 3'd2;
        else                     rot = 3'd1;
        bsamp  = (emax >= 16'd255) ? byte_reg : 8'(byte_reg << rot);
        acc10  = {acc_reg, 3'd0} + {3'd0, acc_reg, 1'b0} + 20'(byte_reg[3:0]);
        scaled = (emax == 16'd255) ? {8'd0, acc_reg} : quotient;
        asamp  = (scaled > 24'd255) ? 8'd255 : scaled[7:0];
    end

    pnm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        logic [7:0] comp;
        logic       emit;
        logic       got;
        logic [7:0] pv;
        state_next   = state_reg;
        emitted_next = emitted_reg;
        slot_next    = slot_reg;
        hred_next    = hred_reg;
        hgrn_next    = hgrn_reg;
        col_next     = col_reg;
        acc_next     = acc_reg;
        innum_next   = innum_reg;
        done_next    = done_reg;
        byte_next    = byte_reg;
        bit_next     = bit_reg;
        ov_next      = ov_reg && !m_axis_tready;
        olast_next   = olast_reg;
        odata_next   = odata_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {acc_reg, 8'd0} - {8'd0, acc_reg};
        div_req.divisor  = emax;
        comp = '0;
        emit = 1'b0;
        got  = 1'b0;
        pv   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    byte_next = s_axis_tdata;
                    bit_next  = '0;
                    if (!done_reg && total != 30'd0)
                    begin
                        state_next = (fmt_reg == FMT_P4) ? ST_BITS : ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
                case (fmt_reg)
                    FMT_P6:
                    begin
                        got  = 1'b1;
                        comp = bsamp;
                    end
                    FMT_P5:
                    begin
                        emit = 1'b1;
                        pv   = bsamp;
                    end
                    FMT_P3, FMT_P2:
                    begin
                        if (byte_reg >= 8'h30 && byte_reg <= 8'h39)
                        begin
                            acc_next   = (acc10 > 20'hFFFF) ? 16'hFFFF : acc10[15:0];
                            innum_next = 1'b1;
                        end
                        else
                        begin
                            if (innum_reg && emax != 16'd255)
                            begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                            else
                            begin
                                if (innum_reg)
                                begin
                                    got  = (fmt_reg == FMT_P3);
                                    emit = (fmt_reg == FMT_P2);
                                    comp = asamp;
                                    pv   = asamp;
                                end
                                acc_next   = '0;
                                innum_next = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                    got  = (fmt_reg == FMT_P3);
                    emit = (fmt_reg == FMT_P2);
                    comp = asamp;
                    pv   = asamp;
                    acc_next   = '0;
                    innum_next = 1'b0;
                end
            end
            ST_BITS:
            begin
                if (!ov_next)
                begin
                    if (col_reg < width_reg && !done_reg)
                    begin
                        emit = 1'b1;
                        pv   = byte_reg[3'd7 - bit_reg] ? 8'd0 : 8'd255;
                    end
                    bit_next = bit_reg + 3'd1;
                    if ({1'b0, col_reg} + 16'd1 >= {1'b0, width_reg})
                    begin
                        col_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        col_next = col_reg + 15'd1;
                        if (bit_reg == 3'd7)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (got)
        begin
            if (slot_reg == 2'd0)
            begin
                hred_next = comp;
                slot_next = 2'd1;
            end
            else if (slot_reg == 2'd1)
            begin
                hgrn_next = comp;
                slot_next = 2'd2;
            end
            else
            begin
                slot_next  = 2'd0;
                emit       = 1'b1;
                odata_next = {comp, hgrn_reg, hred_reg};
            end
        end
        else
        begin
            odata_next = emit ? {pv, pv, pv} : odata_reg;
        end
        if (emit)
        begin
            if (done_reg || emitted_reg >= total)
            begin
                done_next  = 1'b1;
                odata_next = odata_reg;
            end
            else
            begin
                emitted_next = emitted_reg + 30'd1;
                ov_next      = 1'b1;
                olast_next   = (emitted_reg + 30'd1 == total);
                if (emitted_reg + 30'd1 == total)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg     <= FMT_P6;
            width_reg   <= 15'd1;
            height_reg  <= 15'd1;
            maxv_reg    <= 16'd255;
            state_reg   <= ST_IDLE;
            emitted_reg <= '0;
            slot_reg    <= '0;
            hred_reg    <= '0;
            hgrn_reg    <= '0;
            col_reg     <= '0;
            acc_reg     <= '0;
            innum_reg   <= 1'b0;
            done_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            emitted_reg <= emitted_next;
            slot_reg    <= slot_next;
            hred_reg    <= hred_next;
            hgrn_reg    <= hgrn_next;
            col_reg     <= col_next;
            acc_reg     <= acc_next;
            innum_reg   <= innum_next;
            done_reg    <= done_next;
            ov_reg      <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (pnm_reg_t'(cfg_index))
                    REG_FORMAT: fmt_reg    <= cfg_data[2:0];
                    REG_WIDTH:  width_reg  <= cfg_data[14:0];
                    REG_HEIGHT: height_reg <= cfg_data[14:0];
                    REG_MAXVAL: maxv_reg   <= cfg_data;
                    default:    fmt_reg    <= fmt_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        bit_reg   <= bit_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

endmodule
